>>> sv/csm_pkg.sv
// Shared types, constants and arithmetic helpers for the min-max contrast stretch.
// Used by csm_front, csm_queue, csm_back and contrast_stretch_minmax; no dependencies.
package csm_pkg;

	// pixel, product and quotient widths
	localparam int PIX_W       = 8;
	localparam int MAG_W       = 2 * PIX_W;
	localparam int QUO_W       = PIX_W;
	localparam int QIDX_W      = $clog2(QUO_W);
	localparam int DIV_STAGES  = QUO_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PIX_W-1:0] PIX_MIN = '0;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_LOW  = 2'd0,
		CFG_OUT_HIGH = 2'd1
	} cfg_reg_t;

	// pass selector carried in op
	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_MAP     = 1'b1
	} op_t;

	// input word
	typedef struct packed {
		logic             op;
		logic [PIX_W-1:0] pixel_in;
		logic             frame_end;
	} in_t;

	// output word
	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_done;
	} out_t;

	// one map job: |numerator|, sign, divisor, output base, last flag
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic [PIX_W-1:0] den;
		logic [PIX_W-1:0] base;
		logic             last;
	} job_t;

	// divider stage contents
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [PIX_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic [PIX_W-1:0] base;
		logic             last;
	} div_t;

	// front to queue
	typedef struct packed {
		logic push;
		job_t job;
	} q_wr_t;

	// queue head to back
	typedef struct packed {
		logic valid;
		job_t job;
	} q_rd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [PIX_W-1:0] frame_low;
		logic [PIX_W-1:0] frame_high;
		logic             pass_started;
	} front_stat_t;

	// start a division from a queued job
	function automatic div_t div_load(job_t j);
		div_t r;
		r.rem  = j.mag;
		r.den  = j.den;
		r.quo  = '0;
		r.neg  = j.neg;
		r.base = j.base;
		r.last = j.last;
		return r;
	endfunction

	// one restoring step: settle quotient bit b
	function automatic div_t div_step(div_t s, logic [QIDX_W-1:0] b);
		div_t             r;
		logic [MAG_W-1:0] dsh;
		r   = s;
		dsh = MAG_W'(s.den) << b;
		if (s.rem >= dsh) begin
			r.rem    = s.rem - dsh;
			r.quo[b] = 1'b1;
		end
		return r;
	endfunction

	// floor of a signed quotient, then offset by the output base (mod 256)
	function automatic out_t div_finish(div_t s);
		out_t             o;
		logic [PIX_W-1:0] up;
		up = PIX_W'(s.rem != '0);
		if (s.neg) begin
			o.pixel_out = s.base - (s.quo + up);
		end else begin
			o.pixel_out = s.base + s.quo;
		end
		o.frame_done = s.last;
		return o;
	endfunction

endpackage

>>> sv/csm_front.sv
// Front part: running min/max of measure passes and numerator set-up of map pixels.
// Depends on csm_pkg.
module csm_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  csm_pkg::in_t              in_data,
	input  logic [csm_pkg::PIX_W-1:0] out_low,
	input  logic [csm_pkg::PIX_W-1:0] out_high,
	output csm_pkg::q_wr_t            wr,
	output csm_pkg::front_stat_t      stat
);

	logic [csm_pkg::PIX_W-1:0] run_low_q, run_high_q;
	logic [csm_pkg::PIX_W-1:0] frame_low_q, frame_high_q;
	logic                      started_q;

	logic                      is_map;
	logic [csm_pkg::PIX_W-1:0] nxt_low, nxt_high;
	logic [csm_pkg::PIX_W-1:0] pix_c, offs, den, smag;
	logic                      neg;

	assign is_map = (in_data.op == csm_pkg::OP_MAP);

	// next running range for a measure word
	always_comb begin
		if (!started_q) begin
			nxt_low  = in_data.pixel_in;
			nxt_high = in_data.pixel_in;
		end else begin
			nxt_low  = (in_data.pixel_in < run_low_q)  ? in_data.pixel_in : run_low_q;
			nxt_high = (in_data.pixel_in > run_high_q) ? in_data.pixel_in : run_high_q;
		end
	end

	// running and latched range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_low_q    <= csm_pkg::PIX_MAX;
			run_high_q   <= csm_pkg::PIX_MIN;
			started_q    <= 1'b0;
			frame_low_q  <= csm_pkg::PIX_MIN;
			frame_high_q <= csm_pkg::PIX_MAX;
		end else if (accept && !is_map) begin
			if (in_data.frame_end) begin
				frame_low_q  <= nxt_low;
				frame_high_q <= nxt_high;
				run_low_q    <= csm_pkg::PIX_MAX;
				run_high_q   <= csm_pkg::PIX_MIN;
				started_q    <= 1'b0;
			end else begin
				run_low_q  <= nxt_low;
				run_high_q <= nxt_high;
				started_q  <= 1'b1;
			end
		end
	end

	// map set-up: clamp, offset, scale magnitude and one 8x8 product
	always_comb begin
		if (in_data.pixel_in < frame_low_q) begin
			pix_c = frame_low_q;
		end else if (in_data.pixel_in > frame_high_q) begin
			pix_c = frame_high_q;
		end else begin
			pix_c = in_data.pixel_in;
		end
		offs = pix_c - frame_low_q;
		den  = frame_high_q - frame_low_q;
		neg  = (out_high < out_low);
		smag = neg ? (out_low - out_high) : (out_high - out_low);

		wr.push     = accept && is_map;
		wr.job.mag  = csm_pkg::MAG_W'(offs) * csm_pkg::MAG_W'(smag);
		wr.job.neg  = neg;
		// flat frame: numerator is zero, divisor forced to one
		wr.job.den  = (den == '0) ? csm_pkg::PIX_W'(1) : den;
		wr.job.base = out_low;
		wr.job.last = in_data.frame_end;
	end

	assign stat.frame_low    = frame_low_q;
	assign stat.frame_high   = frame_high_q;
	assign stat.pass_started = started_q;

endmodule

>>> sv/csm_queue.sv
// Short job queue between the front and the divider back end.
// Depends on csm_pkg.
module csm_queue #(
	parameter int DEPTH = csm_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csm_pkg::q_wr_t       wr,
	input  logic                 pop,
	output csm_pkg::q_rd_t       head,
	output csm_pkg::queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	csm_pkg::job_t    fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_pop     = pop && !stat.empty;

	assign head.valid = !stat.empty;
	assign head.job   = fifo_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr.push && !stat.full) begin
			fifo_q[wr_ptr_q] <= wr.job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push && !stat.full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((wr.push && !stat.full) && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!(wr.push && !stat.full) && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/csm_back.sv
// Back part: pipelined restoring divider, one quotient bit per stage, plus output register.
// Depends on csm_pkg.
module csm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  csm_pkg::q_rd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output csm_pkg::out_t  out_data
);

	localparam int NS = csm_pkg::DIV_STAGES;

	csm_pkg::div_t   div_s [NS];
	logic [NS-1:0]   vld_s;
	csm_pkg::out_t   out_q;
	logic            out_valid_q;
	logic            en;

	// whole pipe advances unless a finished word is held up
	assign en  = !out_valid_q || out_ready;
	assign pop = en && head.valid;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[NS-2:0], head.valid};
			out_valid_q <= vld_s[NS-1];
		end
	end

	// first stage settles the top quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= csm_pkg::div_step(csm_pkg::div_load(head.job),
				csm_pkg::QIDX_W'(csm_pkg::QUO_W - 1));
		end
	end

	// remaining stages, one bit each
	for (genvar k = 1; k < NS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= csm_pkg::div_step(div_s[k-1],
					csm_pkg::QIDX_W'(csm_pkg::QUO_W - 1 - k));
			end
		end
	end

	// rounding fix-up and base offset into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= csm_pkg::div_finish(div_s[NS-1]);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> sv/contrast_stretch_minmax.sv
// Min-max contrast stretch of 8-bit grey pixels, top level.
// Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one pixel word per handshake. op = 0 words
//     measure the frame range and give no output; frame_end on such a word latches it.
//     op = 1 words are mapped with the latched range and give one out word each.
//   out channel (out_valid/out_ready/out_data): mapped pixel, frame_done copies frame_end.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the low output
//     level, index 1 the high one; other indexes are ignored. cfg_ready is always high;
//     write only while no map word is in flight.
// Path: a map word passes the queue, 8 divider stages of one quotient bit each and the
//   output register before it is presented on out.
// Throughput: one word per cycle, in either pass, while in_ready is high; the clamp and
//   8x8 product of the front is the longest path.
// Reset: output range 0..255, latched frame range 0..255, queue and divider empty.
// Stall: while a word waits on out and out_ready is low, the divider holds; the 4-word
//   queue then fills and in_ready drops until the receiver takes the waiting word.
module contrast_stretch_minmax #(
	parameter int QUEUE_DEPTH = csm_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  csm_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output csm_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [csm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csm_pkg::PIX_W-1:0]     cfg_data
);

	logic [csm_pkg::PIX_W-1:0] out_low_q, out_high_q;
	logic                      accept;
	logic                      pop;
	csm_pkg::q_wr_t            wr;
	csm_pkg::q_rd_t            head;
	csm_pkg::queue_stat_t      q_stat;
	csm_pkg::front_stat_t      f_stat;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;

	// output range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q  <= csm_pkg::PIX_MIN;
			out_high_q <= csm_pkg::PIX_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == csm_pkg::CFG_OUT_LOW) begin
				out_low_q <= cfg_data;
			end else if (cfg_index == csm_pkg::CFG_OUT_HIGH) begin
				out_high_q <= cfg_data;
			end
		end
	end

	csm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_data  (in_data),
		.out_low  (out_low_q),
		.out_high (out_high_q),
		.wr       (wr),
		.stat     (f_stat)
	);

	csm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	csm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// latched frame range is never inverted
	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.frame_low <= f_stat.frame_high)
		else $error("latched frame range inverted");

	// frame end on a measure word restarts the running range
	a_pass_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.op == csm_pkg::OP_MEASURE) && in_data.frame_end
		|=> !f_stat.pass_started)
		else $error("running range not cleared at frame end");

	// an accepted map word lands in the queue
	a_map_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.op == csm_pkg::OP_MAP) |=> !q_stat.empty)
		else $error("map word lost before the queue");
`endif

endmodule

>>> bench/contrast_stretch_minmax_test.sv
`timescale 1ns / 1ps
// Self-checking bench for contrast_stretch_minmax: directed then random measure/map frames.
// Depends on csm_pkg and contrast_stretch_minmax; a scoreboard class tracks the frame range.
module contrast_stretch_minmax_test;
	import csm_pkg::*;

	// indexes that name no register; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int SETTLE_CYCLES = 14;
	localparam int HOLD_CYCLES   = 80;
	localparam int TARGET_WORDS  = 450;

	// running copy of the stretch state and the mapped pixels still owed by the block
	class stretch_ledger;
		logic [PIX_W-1:0] out_low, out_high;
		logic [PIX_W-1:0] run_low, run_high, frame_low, frame_high;
		logic             started;
		out_t             owed_pixels[$];
		int               errors;

		function void clear();
			out_low    = PIX_MIN;
			out_high   = PIX_MAX;
			run_low    = PIX_MAX;
			run_high   = PIX_MIN;
			started    = 1'b0;
			frame_low  = PIX_MIN;
			frame_high = PIX_MAX;
			owed_pixels.delete();
			errors     = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int owed();
			return owed_pixels.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
			case (idx)
				CFG_OUT_LOW: begin
					out_low = data;
				end
				CFG_OUT_HIGH: begin
					out_high = data;
				end
				default: begin
				end
			endcase
		endfunction

		// clamp to the latched range, scale exactly, floor towards minus infinity
		function logic [PIX_W-1:0] stretch_pixel(logic [PIX_W-1:0] p);
			int v, den, num, q;
			v = int'(p);
			if (v < int'(frame_low)) v = int'(frame_low);
			if (v > int'(frame_high)) v = int'(frame_high);
			den = int'(frame_high) - int'(frame_low);
			if (den <= 0) return out_low;
			num = (v - int'(frame_low)) * (int'(out_high) - int'(out_low));
			if (num >= 0) q = num / den;
			else q = -((-num + den - 1) / den);
			return PIX_W'(int'(out_low) + q);
		endfunction

		// accepted input word: measure updates the range, map owes one output word
		function void note_word(in_t w);
			out_t o;
			if (op_t'(w.op) == OP_MEASURE) begin
				if (!started) begin
					run_low  = w.pixel_in;
					run_high = w.pixel_in;
					started  = 1'b1;
				end else begin
					if (w.pixel_in < run_low) run_low = w.pixel_in;
					if (w.pixel_in > run_high) run_high = w.pixel_in;
				end
				if (w.frame_end) begin
					frame_low  = run_low;
					frame_high = run_high;
					run_low    = PIX_MAX;
					run_high   = PIX_MIN;
					started    = 1'b0;
				end
			end else begin
				o.pixel_out  = stretch_pixel(w.pixel_in);
				o.frame_done = w.frame_end;
				owed_pixels.push_back(o);
			end
		endfunction

		task check_word(out_t got);
			out_t want;
			if (owed_pixels.size() == 0) begin
				report($sformatf("unexpected word pixel_out=%0d frame_done=%0d",
					got.pixel_out, got.frame_done));
			end else begin
				want = owed_pixels.pop_front();
				if (got.pixel_out !== want.pixel_out)
					report($sformatf("pixel_out got %0d want %0d",
						got.pixel_out, want.pixel_out));
				if (got.frame_done !== want.frame_done)
					report($sformatf("frame_done got %0d want %0d",
						got.frame_done, want.frame_done));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_data;

	stretch_ledger ledger;
	int            words_sent;
	bit            no_gaps;
	bit            hold_off_due;

	contrast_stretch_minmax dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// mostly short gaps, a few long ones, none at all in eager stretches
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic in_t make_word(op_t op, int p, bit last);
		in_t w;
		w.op        = op;
		w.pixel_in  = PIX_W'(p);
		w.frame_end = last;
		return w;
	endfunction

	// handshake monitor: all three channels seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) ledger.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) ledger.note_word(in_data);
			if (out_valid && out_ready) ledger.check_word(out_data);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
		cfg_index = idx;
		cfg_data  = PIX_W'(data);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// block idle: in_valid dropped, every owed word back, then a wait of SETTLE_CYCLES
	task automatic settle();
		in_valid = 1'b0;
		while (ledger.owed() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// receiver: runs of ready, random stalls, one long hold-off on request
	initial begin : receiver
		int run_left, stall_left, hold_left;
		bit hold_seen;
		run_left   = 0;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 1'b0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_due && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				out_ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				run_left   = $urandom_range(0, 15);
				stall_left = pick_gap();
				out_ready  = 1'b1;
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int frame, lo, hi, span, k, m, i, p, pick;
		bit last;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_OUT_LOW;
		cfg_data     = '0;
		no_gaps      = 1'b0;
		hold_off_due = 1'b0;
		words_sent   = 0;
		ledger       = new;
		ledger.clear();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// map straight after reset: identity over the full range
		send_word(make_word(OP_MAP, 0, 1'b0));
		send_word(make_word(OP_MAP, 255, 1'b0));
		send_word(make_word(OP_MAP, 128, 1'b0));
		// frame end on the first measure word gives a flat frame
		send_word(make_word(OP_MEASURE, 77, 1'b1));
		send_word(make_word(OP_MAP, 0, 1'b0));
		send_word(make_word(OP_MAP, 77, 1'b0));
		send_word(make_word(OP_MAP, 255, 1'b1));
		// range 10..200, then pixels below, inside and above it
		send_word(make_word(OP_MEASURE, 10, 1'b0));
		send_word(make_word(OP_MEASURE, 200, 1'b0));
		send_word(make_word(OP_MEASURE, 50, 1'b1));
		send_word(make_word(OP_MAP, 0, 1'b0));
		send_word(make_word(OP_MAP, 105, 1'b0));
		send_word(make_word(OP_MAP, 255, 1'b0));
		// map word in the middle of a measure pass keeps the old range
		send_word(make_word(OP_MEASURE, 30, 1'b0));
		send_word(make_word(OP_MAP, 200, 1'b0));
		send_word(make_word(OP_MEASURE, 90, 1'b1));
		send_word(make_word(OP_MAP, 60, 1'b1));
		settle();

		// reversed output range, plus writes to spare indexes
		write_reg(CFG_OUT_LOW, 255);
		write_reg(CFG_OUT_HIGH, 0);
		write_reg(CFG_SPARE_A, 17);
		write_reg(CFG_SPARE_B, 170);
		send_word(make_word(OP_MAP, 30, 1'b0));
		send_word(make_word(OP_MAP, 47, 1'b0));
		send_word(make_word(OP_MAP, 90, 1'b1));
		settle();

		// zero-width output range, then full input range
		write_reg(CFG_OUT_LOW, 200);
		write_reg(CFG_OUT_HIGH, 200);
		send_word(make_word(OP_MAP, 47, 1'b1));
		send_word(make_word(OP_MEASURE, 0, 1'b0));
		send_word(make_word(OP_MEASURE, 255, 1'b1));
		send_word(make_word(OP_MAP, 1, 1'b1));
		settle();
		write_reg(CFG_OUT_LOW, 0);
		write_reg(CFG_OUT_HIGH, 255);

		// random frames: measure pass with random content, then a map pass
		frame = 0;
		while (words_sent < TARGET_WORDS) begin
			frame++;
			if (frame % 6 == 0) begin
				settle();
				pick = $urandom_range(0, 4);
				case (pick)
					0: begin lo = 0; hi = 255; end
					1: begin lo = 255; hi = 0; end
					2: begin lo = $urandom_range(0, 255); hi = lo; end
					default: begin
						lo = $urandom_range(0, 255);
						hi = $urandom_range(0, 255);
					end
				endcase
				if ($urandom_range(0, 1)) begin
					write_reg(CFG_OUT_HIGH, hi);
					write_reg(CFG_OUT_LOW, lo);
				end else begin
					write_reg(CFG_OUT_LOW, lo);
					write_reg(CFG_OUT_HIGH, hi);
				end
				if ($urandom_range(0, 3) == 0)
					write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
						$urandom_range(0, 255));
			end
			no_gaps = ($urandom_range(0, 5) == 0);

			lo = $urandom_range(0, 255);
			case ($urandom_range(0, 3))
				0: span = 0;
				1: span = $urandom_range(1, 4);
				default: span = $urandom_range(0, 255);
			endcase
			hi = (lo + span > 255) ? 255 : lo + span;

			// measure pass; now and then left open or sprinkled with map words
			k = $urandom_range(1, 10);
			for (i = 0; i < k; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_word(make_word(OP_MAP, $urandom_range(0, 255),
						1'($urandom_range(0, 1))));
				last = (i == k - 1) && ($urandom_range(0, 9) != 0);
				send_word(make_word(OP_MEASURE, $urandom_range(lo, hi), last));
			end

			// long map pass under a receiver hold-off so the block backs up
			if (frame == 2) begin
				no_gaps      = 1'b1;
				m            = 40;
				hold_off_due = 1'b1;
			end else begin
				m = $urandom_range(1, 16);
			end
			for (i = 0; i < m; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					send_word(make_word(OP_MEASURE, $urandom_range(0, 255), 1'b0));
				end
				p    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
					: $urandom_range(lo, hi);
				last = (i == m - 1) || ($urandom_range(0, 19) == 0);
				send_word(make_word(OP_MAP, p, last));
			end
		end

		settle();
		if (ledger.errors == 0 && ledger.owed() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
